// ===== sv/mbp_pkg.sv =====
// Package for the MSB-first bit packer: action codes, field limits and the
// command word passed from the front end to the back end through the queue.
// No dependencies.
package mbp_pkg;

  // Largest field the writer accepts; wider requests are clamped to it.
  localparam int MAX_FIELD_BITS = 32;
  localparam int FIELD_LIMIT    = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;

  // Action codes on the input channel.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Reset value of the capacity register, in bytes.
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // One queued command: up to four result words to emit.
  typedef struct packed {
    logic [31:0] data;         // bytes to emit, first byte in the top lane
    logic [2:0]  nres;         // number of result words, 1 to 4
    logic [15:0] first_count;  // byte count carried by the first word
    logic        byte_valid;   // words carry stream bytes
    logic        overflow;     // write was refused
  } mbp_cmd_t;

endpackage

// ===== sv/mbp_ifs.sv =====
// Valid/ready channel interfaces of the bit packer: the input item channel
// and the result channel. No dependencies.
interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] field_value;
  logic [5:0]  field_width;

  modport source (output valid, action, field_value, field_width, input ready);
  modport sink   (input valid, action, field_value, field_width, output ready);
endinterface

interface mbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic        overflow;
  logic [15:0] byte_count;

  modport source (output valid, out_byte, byte_valid, last, overflow, byte_count,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, last, overflow, byte_count,
                  output ready);
endinterface

// ===== sv/mbp_front.sv =====
// Front end of the bit packer: accepts items, merges fields into the partial
// byte, checks capacity and queues one command per item that gives results.
// Depends on mbp_pkg and mbp_in_if.
module mbp_front
  import mbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  mbp_in_if.sink          in_if,
  output logic            push,
  output mbp_cmd_t        push_cmd,
  input  logic            q_full
);

  logic [7:0]  partial_r, partial_nxt;
  logic [2:0]  bitpos_r, bitpos_nxt;
  logic [15:0] bytes_done_r, bytes_done_nxt;
  logic [15:0] cap_r;

  logic        accept;
  logic        is_flush;
  logic [5:0]  width;
  logic [4:0]  shamt;
  logic [31:0] field_aligned;
  logic [39:0] window;
  logic [5:0]  total;
  logic [2:0]  nbytes;
  logic [7:0]  new_partial;
  logic [19:0] used;
  logic [19:0] room;
  logic        refused;

  // The front takes an item whenever the queue has room.
  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign is_flush    = (in_if.action == ACT_FLUSH);

  // Clamp the width and left-align the field; the shift drops unused bits.
  assign width = (in_if.field_width > 6'(FIELD_LIMIT)) ? 6'(FIELD_LIMIT)
                                                       : in_if.field_width;
  assign shamt         = 5'(6'd32 - width);
  assign field_aligned = in_if.field_value << shamt;

  // Place the field right after the bits already held in the partial byte.
  assign window = {partial_r, 32'b0} | ({field_aligned, 8'b0} >> bitpos_r);
  assign total  = {3'b0, bitpos_r} + width;
  assign nbytes = total[5:3];

  // The leftover bits start at the first byte lane not completed.
  always_comb begin
    unique case (nbytes)
      3'd0:    new_partial = window[39:32];
      3'd1:    new_partial = window[31:24];
      3'd2:    new_partial = window[23:16];
      3'd3:    new_partial = window[15:8];
      3'd4:    new_partial = window[7:0];
      default: new_partial = 8'h00;
    endcase
  end

  // Capacity check in bits.
  assign used    = {1'b0, bytes_done_r, 3'b0} + 20'(bitpos_r) + 20'(width);
  assign room    = {1'b0, cap_r, 3'b0};
  assign refused = (used > room);

  // Command and next state.
  always_comb begin
    push           = 1'b0;
    push_cmd       = '0;
    partial_nxt    = partial_r;
    bitpos_nxt     = bitpos_r;
    bytes_done_nxt = bytes_done_r;
    if (accept) begin
      if (is_flush) begin
        push                 = 1'b1;
        push_cmd.data        = {partial_r, 24'b0};
        push_cmd.nres        = 3'd1;
        push_cmd.byte_valid  = (bitpos_r != 3'd0);
        push_cmd.first_count = bytes_done_r + 16'(bitpos_r != 3'd0);
        partial_nxt          = 8'h00;
        bitpos_nxt           = 3'd0;
        bytes_done_nxt       = 16'h0000;
      end else if (width != 6'd0) begin
        if (refused) begin
          push                 = 1'b1;
          push_cmd.nres        = 3'd1;
          push_cmd.overflow    = 1'b1;
          push_cmd.first_count = bytes_done_r;
        end else begin
          push                 = (nbytes != 3'd0);
          push_cmd.data        = window[39:8];
          push_cmd.nres        = nbytes;
          push_cmd.byte_valid  = 1'b1;
          push_cmd.first_count = bytes_done_r + 16'd1;
          partial_nxt          = new_partial;
          bitpos_nxt           = total[2:0];
          bytes_done_nxt       = bytes_done_r + 16'(nbytes);
        end
      end
    end
  end

  // Writer state and capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r    <= 8'h00;
      bitpos_r     <= 3'd0;
      bytes_done_r <= 16'h0000;
      cap_r        <= CAPACITY_RESET;
    end else begin
      partial_r    <= partial_nxt;
      bitpos_r     <= bitpos_nxt;
      bytes_done_r <= bytes_done_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

`ifndef SYNTHESIS
  // Bits of the partial byte not yet filled are always zero.
  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r & (8'hFF >> bitpos_r)) == 8'h00)
    else $error("partial byte holds bits beyond the fill position");

  // A refused write leaves the writer state untouched.
  a_refuse_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_flush && width != 6'd0 && refused) |=>
      ($stable(partial_r) && $stable(bitpos_r) && $stable(bytes_done_r)))
    else $error("refused write changed the writer state");
`endif

endmodule

// ===== sv/mbp_queue.sv =====
// Short command queue between the front and back ends of the bit packer.
// Depends on mbp_pkg.
module mbp_queue
  import mbp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mbp_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output mbp_cmd_t head_cmd,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mbp_cmd_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("command queue count beyond its depth");
`endif

endmodule

// ===== sv/mbp_back.sv =====
// Back end of the bit packer: unrolls each queued command into result words,
// one per cycle while the result channel is ready, through an output register.
// Depends on mbp_pkg and mbp_out_if.
module mbp_back
  import mbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mbp_cmd_t head_cmd,
  input  logic     q_empty,
  output logic     pop,
  mbp_out_if.source out_if
);

  logic        cur_valid_r, cur_valid_nxt;
  logic [31:0] cur_data_r, cur_data_nxt;
  logic [2:0]  cur_rem_r, cur_rem_nxt;
  logic [15:0] cur_count_r, cur_count_nxt;
  logic        cur_bv_r, cur_bv_nxt;
  logic        cur_ovf_r, cur_ovf_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_bv_r, out_bv_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_ovf_r, out_ovf_nxt;
  logic [15:0] out_count_r, out_count_nxt;

  logic        advance;
  logic        cur_done;

  // A word moves to the output register when it is empty or being taken.
  assign advance  = cur_valid_r && (!out_valid_r || out_if.ready);
  assign cur_done = advance && (cur_rem_r == 3'd1);
  assign pop      = !q_empty && (!cur_valid_r || cur_done);

  // Working command and output register next values.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_data_nxt  = cur_data_r;
    cur_rem_nxt   = cur_rem_r;
    cur_count_nxt = cur_count_r;
    cur_bv_nxt    = cur_bv_r;
    cur_ovf_nxt   = cur_ovf_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_count_nxt = out_count_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_data_r[31:24];
      out_bv_nxt    = cur_bv_r;
      out_last_nxt  = (cur_rem_r == 3'd1);
      out_ovf_nxt   = cur_ovf_r;
      out_count_nxt = cur_count_r;
      cur_data_nxt  = {cur_data_r[23:0], 8'h00};
      cur_rem_nxt   = cur_rem_r - 3'd1;
      cur_count_nxt = cur_count_r + 16'd1;
      cur_valid_nxt = (cur_rem_r != 3'd1);
    end
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_data_nxt  = head_cmd.data;
      cur_rem_nxt   = head_cmd.nres;
      cur_count_nxt = head_cmd.first_count;
      cur_bv_nxt    = head_cmd.byte_valid;
      cur_ovf_nxt   = head_cmd.overflow;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_data_r  <= cur_data_nxt;
    cur_rem_r   <= cur_rem_nxt;
    cur_count_r <= cur_count_nxt;
    cur_bv_r    <= cur_bv_nxt;
    cur_ovf_r   <= cur_ovf_nxt;
    out_byte_r  <= out_byte_nxt;
    out_bv_r    <= out_bv_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_byte   = out_byte_r;
  assign out_if.byte_valid = out_bv_r;
  assign out_if.last       = out_last_r;
  assign out_if.overflow   = out_ovf_r;
  assign out_if.byte_count = out_count_r;

`ifndef SYNTHESIS
  // A word without a stream byte carries a zero byte.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bv_r) |-> (out_byte_r == 8'h00))
    else $error("word without a stream byte carries nonzero data");

  // A refusal is always a single, final word.
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_last_r && !out_bv_r))
    else $error("overflow word not marked last or carries a byte");

  // A working command always has words left to send.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_rem_r != 3'd0))
    else $error("active command with no words left");
`endif

endmodule

// ===== sv/msb_first_bit_packer_unit.sv =====
// MSB-first bit packer. Each input word either writes a field of 1 to 32 bits
// (wider requests are clamped, zero width is a no-op) or flushes the message.
// The front end takes one input word per cycle while its command queue has
// room; the result channel moves one word per cycle from a registered output
// stage while the receiver is ready. An item gives no result word for a write
// that completes no byte, one for a flush or a refused write, and up to four
// for a 32-bit write. Sustained throughput is therefore set by the result
// channel at one word per cycle. Capacity must be written on cfg_we/cfg_wdata
// only while the unit is idle, by the user; the unit does not enforce this.
// Depends on mbp_pkg, mbp_ifs, mbp_front, mbp_queue and mbp_back.
module msb_first_bit_packer_unit
  import mbp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mbp_in_if.sink      in_if,
  mbp_out_if.source   out_if
);

  logic     push;
  mbp_cmd_t push_cmd;
  logic     q_full;
  logic     pop;
  mbp_cmd_t head_cmd;
  logic     q_empty;

  // Accept, merge and classify input words.
  mbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  // Decouple the two sides.
  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  // Emit result words.
  mbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule
